/* rtl/core/aazw_pkg.sv */
// Shared constants and types for the angle averaging block.
`timescale 1ns / 1ps
package aazw_pkg;

  localparam int SAMPLES_DEF   = 8;
  localparam int FRAC_BITS_DEF = 4;

  localparam int RAW_W   = 16;
  localparam int SMP_W   = 12;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int SUM_W   = 18;
  localparam int TURN_W  = 16;
  localparam int ANG_W   = 17;

  // Request codes carried by the func field on the last sample of a window.
  localparam logic REQ_UPDATE   = 1'b0;
  localparam logic REQ_SET_ZERO = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/core/aazw_div.sv */
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps
module aazw_div
  import aazw_pkg::*;
#(
  parameter int DIV_W = SUM_W + FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output div_stat_t        stat
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] q_r;
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;

  // The remainder stays below the divisor, so it fits the divisor's width.
  assign trial = {rem_r, q_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(DIV_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  assign quotient  = q_r;
  assign stat.busy = cnt_r != '0;
  assign stat.done = done_r;

endmodule

/* rtl/core/angle_average_zero_wrap.sv */
// Top level: window accumulation, sequencer, zero offset and wrapped angle output.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall   in_raw_word[15:0], in_read_ok, in_func
// out      output     out_valid / out_stall out_angle[16:0] signed, out_updated
//
// A sample inside the window is a one-cycle transfer. The window's last sample
// starts the divider, which retires one quotient bit per cycle, and the input
// then stalls until the result is loaded into the output register. A window
// with no good reads skips the divider and goes straight to that load.
// Reset is synchronous and active low and clears the window, the zero offset
// and the held angle. The result sits in an output register, so a stalled
// result only blocks the input once the next window end needs that register.
module angle_average_zero_wrap
  import aazw_pkg::*;
#(
  parameter int SAMPLES   = SAMPLES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [RAW_W-1:0]        in_raw_word,
  input  logic                    in_read_ok,
  input  logic                    in_func,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ANG_W-1:0] out_angle,
  output logic                    out_updated
);

  // The dividend is the window sum scaled by the fraction bits.
  localparam int DIV_W = SUM_W + FRAC_BITS;
  // Scaling from 12.FRAC_BITS down or up to 1/65536 turn.
  localparam int LSH = (FRAC_BITS <= 4) ? 4 - FRAC_BITS : 0;
  localparam int RSH = (FRAC_BITS > 4) ? FRAC_BITS - 4 : 0;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]        idx_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [SUM_W-1:0]        sum_r;
  logic [TURN_W-1:0]       zero_r;
  logic signed [ANG_W-1:0] held_r;
  logic                    func_r;
  logic                    upd_r;

  logic                    out_valid_r;
  logic signed [ANG_W-1:0] out_angle_r;
  logic                    out_updated_r;

  logic                    in_fire;
  logic                    last;
  logic [SUM_W-1:0]        sum_fin;
  logic [CNT_W-1:0]        cnt_fin;
  logic                    out_free;
  logic                    div_start;
  logic                    load_out;

  logic [DIV_W-1:0]        quotient;
  div_stat_t               div_stat;

  logic [TURN_W-1:0]       avg;
  logic signed [ANG_W:0]   diff;
  logic signed [ANG_W:0]   wrapped;
  logic signed [ANG_W-1:0] new_angle;

  assign in_stall = state_r != ST_IDLE;
  assign in_fire  = in_valid && !in_stall;
  assign last     = ({1'b0, idx_r} + 7'd1) >= 7'(SAMPLES);
  assign out_free = !out_valid_r || !out_stall;

  // Running totals including the sample on the input right now.
  assign sum_fin = in_read_ok ? sum_r + SUM_W'(in_raw_word[SMP_W-1:0]) : sum_r;
  assign cnt_fin = in_read_ok ? cnt_r + CNT_W'(1) : cnt_r;

  aazw_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(DIV_W'(sum_fin) << FRAC_BITS),
    .divisor (cnt_fin),
    .quotient(quotient),
    .stat    (div_stat)
  );

  // Next state of the window-end sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && last) begin
          state_nxt = (cnt_fin != '0) ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer strobes.
  always_comb begin
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: div_start = in_fire && last && (cnt_fin != '0);
      ST_DIV:  ;
      ST_DONE: load_out = out_free;
      default: ;
    endcase
  end

  // Average in 1/65536 turn, then the offset difference folded into the half-turn range.
  assign avg     = TURN_W'((quotient << LSH) >> RSH);
  assign diff    = $signed({2'b00, avg}) - $signed({2'b00, zero_r});
  always_comb begin
    wrapped = diff;
    if (diff > 18'sd32768) begin
      wrapped = diff - 18'sd65536;
    end else if (diff <= -18'sd32768) begin
      wrapped = diff + 18'sd65536;
    end
  end

  always_comb begin
    new_angle = held_r;
    if (upd_r) begin
      new_angle = (func_r == REQ_SET_ZERO) ? '0 : wrapped[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      zero_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        if (last) begin
          idx_r <= '0;
          cnt_r <= '0;
          sum_r <= '0;
        end else begin
          idx_r <= idx_r + IDX_W'(1);
          cnt_r <= cnt_fin;
          sum_r <= sum_fin;
        end
      end
      if (load_out) begin
        held_r <= new_angle;
        if (upd_r && (func_r == REQ_SET_ZERO)) begin
          zero_r <= avg;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and outcome of the closing window, and the result payload.
  always_ff @(posedge clk) begin
    if (in_fire && last) begin
      func_r <= in_func;
      upd_r  <= cnt_fin != '0;
    end
    if (load_out) begin
      out_angle_r   <= new_angle;
      out_updated_r <= upd_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_angle   = out_angle_r;
  assign out_updated = out_updated_r;

  // No sample may be taken while the divider is still running.
  a_no_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && div_stat.busy))
    else $error("input transfer while divider busy");

  // A new result never overwrites one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !(out_valid_r && out_stall))
    else $error("pending result overwritten");

  // The divider only finishes while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DIV)
    else $error("divider done outside divide state");

  // A shown result always matches the held angle.
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_angle_r == held_r)
    else $error("result angle differs from held angle");

endmodule

/* tb/angle_average_zero_wrap_tb.sv */
// Self-checking testbench for the angle averaging block with zero offset and half-turn wrap.
`timescale 1ns / 1ps
module angle_average_zero_wrap_tb;
  import aazw_pkg::*;

  // The block is built at its package defaults, and the angle tracker below uses the same values.
  localparam int SAMPLES   = SAMPLES_DEF;
  localparam int FRAC_BITS = FRAC_BITS_DEF;

  localparam logic [RAW_W-1:0] RAW_MASK = 16'h0FFF;
  localparam int HALF_TURN = 32768;
  localparam int FULL_TURN = 65536;

  // Quiet spell after the last expected angle, in which any stray result would show.
  localparam int DRAIN_CYCLES = 40;
  // Watchdog limit for the whole run of about 240 windows.
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum {
    WIN_MIXED,
    WIN_NO_READS,
    WIN_FLAT,
    WIN_SINGLE
  } window_kind_t;

  typedef struct {
    logic signed [ANG_W-1:0] angle;
    logic                    updated;
  } angle_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [RAW_W-1:0]        in_raw_word = '0;
  logic                    in_read_ok = 1'b0;
  logic                    in_func = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [ANG_W-1:0] out_angle;
  logic                    out_updated;

  angle_average_zero_wrap #(
    .SAMPLES  (SAMPLES),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_raw_word(in_raw_word),
    .in_read_ok (in_read_ok),
    .in_func    (in_func),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_angle  (out_angle),
    .out_updated(out_updated)
  );

  always #5 clk = ~clk;

  // Angle tracker state. It mirrors the block's state after reset, which is all zero.
  logic [IDX_W-1:0]        win_index  = '0;
  logic [CNT_W-1:0]        win_count  = '0;
  logic [SUM_W-1:0]        win_sum    = '0;
  logic [TURN_W-1:0]       zero_pos   = '0;
  logic signed [ANG_W-1:0] last_angle = '0;

  // Angles expected at the output, oldest first.
  angle_result_t pending_angles[$];

  // Knobs for the sender's bursts and gaps and for the receiver's stall runs.
  int burst_left = 0;
  int burst_max  = 1;
  int gap_max    = 0;
  int stall_pct  = 0;
  int stall_max  = 1;
  int stall_run  = 0;

  int fail_count   = 0;
  int cycle_count  = 0;
  int n_samples    = 0;
  int n_angles     = 0;
  int n_averaged   = 0;
  int n_held       = 0;
  int n_set_zero   = 0;
  int n_wraps      = 0;

  // Average over the window in 1/65536 turn: the sum is scaled to 12.FRAC_BITS,
  // divided with truncation, then shifted to 16 bits of turn.
  function automatic logic [TURN_W-1:0] average_turn16(input logic [SUM_W-1:0] sum,
                                                       input logic [CNT_W-1:0] count);
    longint unsigned q;
    q = 64'(sum);
    q = (q << FRAC_BITS) / 64'(count);
    if (FRAC_BITS <= 4) begin
      q = q << (4 - FRAC_BITS);
    end else begin
      q = q >> (FRAC_BITS - 4);
    end
    return q[TURN_W-1:0];
  endfunction

  // Advances the angle tracker by one accepted sample. On the window's last sample
  // it settles the new angle and queues the result that the block must produce.
  task automatic track_sample(input logic [RAW_W-1:0] raw, input logic ok, input logic fn);
    logic [TURN_W-1:0] avg;
    logic signed [31:0] diff;
    logic               updated;
    n_samples++;
    if (ok) begin
      win_sum   = win_sum + SUM_W'(raw & RAW_MASK);
      win_count = win_count + CNT_W'(1);
    end
    if (int'(win_index) + 1 < SAMPLES) begin
      win_index = win_index + IDX_W'(1);
      return;
    end
    updated = 1'b0;
    // A window without a single good read leaves the offset and the held angle alone,
    // whatever the request says.
    if (win_count != 0) begin
      avg = average_turn16(win_sum, win_count);
      updated = 1'b1;
      if (fn == REQ_SET_ZERO) begin
        zero_pos   = avg;
        last_angle = '0;
        n_set_zero++;
      end else begin
        diff = $signed({16'd0, avg}) - $signed({16'd0, zero_pos});
        // Fold into (-half turn, +half turn]: exactly +half turn stays, -half turn flips.
        if (diff > HALF_TURN) begin
          diff = diff - FULL_TURN;
          n_wraps++;
        end
        if (diff <= -HALF_TURN) begin
          diff = diff + FULL_TURN;
          n_wraps++;
        end
        last_angle = diff[ANG_W-1:0];
      end
    end
    win_index = '0;
    win_count = '0;
    win_sum   = '0;
    pending_angles.push_back('{angle: last_angle, updated: updated});
  endtask

  // Sends one sample and returns at the clock edge where the transfer happens. Valid
  // stays high into the next call, so bursts run back to back. A gap opens only when
  // a burst is used up.
  task automatic send_sample(input logic [RAW_W-1:0] raw, input logic ok, input logic fn);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(burst_max, 1);
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_raw_word <= raw;
    in_read_ok  <= ok;
    in_func     <= fn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_sample(raw, ok, fn);
  endtask

  // Stops sending and waits until every queued angle has come out, plus a quiet spell.
  task automatic wait_for_all_angles();
    in_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One window of random content. Most windows are mixed reads; the others have no
  // good read, a single good read, or one level held flat so that the averages land
  // on the half-turn edges and on the extremes of the sample range.
  task automatic send_random_window();
    int               pick;
    window_kind_t     kind;
    logic [SMP_W-1:0] flat_level;
    int               lone_slot;
    logic [RAW_W-1:0] raw;
    logic             ok;
    logic             fn;
    pick = $urandom_range(99);
    if (pick < 60) begin
      kind = WIN_MIXED;
    end else if (pick < 70) begin
      kind = WIN_NO_READS;
    end else if (pick < 90) begin
      kind = WIN_FLAT;
    end else begin
      kind = WIN_SINGLE;
    end
    case ($urandom_range(5))
      0: flat_level = 12'h000;
      1: flat_level = 12'h800;
      2: flat_level = 12'hFFF;
      3: flat_level = 12'h7FF;
      4: flat_level = 12'h801;
      default: flat_level = SMP_W'($urandom_range(12'hFFF));
    endcase
    lone_slot = $urandom_range(SAMPLES - 1);
    for (int i = 0; i < SAMPLES; i++) begin
      raw = RAW_W'($urandom_range(16'hFFFF));
      ok  = ($urandom_range(99) < 80);
      case (kind)
        WIN_NO_READS: ok = 1'b0;
        WIN_FLAT: begin
          raw = {raw[RAW_W-1:SMP_W], flat_level};
          ok  = 1'b1;
        end
        WIN_SINGLE: ok = (i == lone_slot);
        default: ;
      endcase
      fn = ($urandom_range(99) < 30) ? REQ_SET_ZERO : REQ_UPDATE;
      send_sample(raw, ok, fn);
    end
  endtask

  task automatic run_random_windows(input int count);
    repeat (count) send_random_window();
  endtask

  // Directed windows right after reset, with no idling on either side.
  task automatic test_reset_and_corners();
    logic [RAW_W-1:0] raw;
    logic             ok;
    // Every read fails: the set-zero request is dropped and the reset angle is repeated.
    for (int i = 0; i < SAMPLES; i++) begin
      send_sample(RAW_W'($urandom_range(16'hFFFF)), 1'b0,
                  (i == SAMPLES - 1) ? REQ_SET_ZERO : 1'($urandom_range(1)));
    end
    // Good reads at half a turn mixed with failed all-ones reads, high bits set on the
    // good ones. The last read fails but its set-zero request still counts, so the
    // offset becomes exactly half a turn.
    for (int i = 0; i < SAMPLES; i++) begin
      ok  = (i % 2 == 0);
      raw = ok ? {4'($urandom_range(15)), 12'h800} : 16'hFFFF;
      send_sample(raw, ok, (i == SAMPLES - 1) ? REQ_SET_ZERO : REQ_UPDATE);
    end
    // Samples that mask to zero against a half-turn offset: the difference is exactly
    // minus half a turn and must come out as plus half a turn.
    for (int i = 0; i < SAMPLES; i++) begin
      send_sample(16'hF000, 1'b1, REQ_UPDATE);
    end
    wait_for_all_angles();
  endtask

  task automatic test_back_to_back();
    burst_left = 0;
    gap_max    = 0;
    stall_pct  = 0;
    run_random_windows(60);
    wait_for_all_angles();
  endtask

  task automatic test_sender_bursts();
    burst_left = 0;
    burst_max  = 10;
    gap_max    = 6;
    stall_pct  = 0;
    run_random_windows(60);
    wait_for_all_angles();
  endtask

  // The receiver stalls in runs long enough to back up the output register. Halfway
  // the sender holds off until every queued angle has been taken.
  task automatic test_receiver_stalls();
    burst_left = 0;
    gap_max    = 0;
    stall_pct  = 30;
    stall_max  = 30;
    run_random_windows(30);
    wait_for_all_angles();
    run_random_windows(30);
    wait_for_all_angles();
  endtask

  task automatic test_full_pressure();
    burst_left = 0;
    burst_max  = 6;
    gap_max    = 8;
    stall_pct  = 20;
    stall_max  = 12;
    run_random_windows(58);
    wait_for_all_angles();
  endtask

  // Receiver: stall runs of random length start at random, so stalls fall on every
  // phase of the divider and of the output register.
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      stall_run = $urandom_range(stall_max, 1) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Output checker: each result transfer is compared with the oldest queued angle.
  always @(posedge clk) begin
    angle_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected result: out_angle %0d out_updated %0b", out_angle, out_updated);
        fail_count++;
      end else begin
        want = pending_angles.pop_front();
        n_angles++;
        if (want.updated) begin
          n_averaged++;
        end else begin
          n_held++;
        end
        if (out_angle !== want.angle) begin
          $error("out_angle: expected %0d, actual %0d", want.angle, out_angle);
          fail_count++;
        end
        if (out_updated !== want.updated) begin
          $error("out_updated: expected %0b, actual %0b", want.updated, out_updated);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d angles still expected",
               cycle_count, pending_angles.size());
      $display("angle_average_zero_wrap_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_and_corners();
    test_back_to_back();
    test_sender_bursts();
    test_receiver_stalls();
    test_full_pressure();
    if (pending_angles.size() != 0) begin
      $error("%0d expected angles never arrived", pending_angles.size());
      fail_count++;
    end
    $display("Sent %0d samples; checked %0d window results (%0d averaged, %0d held).",
             n_samples, n_angles, n_averaged, n_held);
    $display("Zero offset set %0d times; %0d angles folded at the half turn.",
             n_set_zero, n_wraps);
    if (fail_count == 0) begin
      $display("angle_average_zero_wrap_tb OK");
    end else begin
      $display("angle_average_zero_wrap_tb NOT OK");
    end
    $finish;
  end

endmodule
